### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs nothing else; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, quiet while reset is low.
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define RHC_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check across reset failed");

`endif

### rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RGB/HSL converter.
// No dependencies; used by the converter, its divider and its checker.
package rhc_pkg;

    // Fixed-point scales
    localparam logic [11:0] FULL       = 12'd4095;
    localparam logic [12:0] SIXTY      = 13'd960;
    localparam logic [12:0] TURN       = 13'd5760;
    localparam logic [12:0] HUE_OFFSET = 13'd1920;

    // Pipelined restoring divider shape: numerator = remainder + quotient bits
    localparam int DIV_DW = 22;
    localparam int DIV_QW = 13;
    localparam int DIV_NW = DIV_DW + DIV_QW;

    // Ramp denominator 2*SIXTY*FULL/2 and its half for rounding
    localparam logic [DIV_DW-1:0] RAMP_DEN  = 22'd3931200;
    localparam logic [33:0]       RAMP_HALF = 34'd1965600;

    // Pipeline depth ahead of the divider
    localparam int PRE_STAGES = 4;

    // Configuration register indexes
    localparam logic REG_DIRECTION = 1'b0;

    // Which component holds the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_max_sel;

    // Data that rides beside the divider
    typedef struct packed {
        logic [11:0] l;
        logic        special;
    } t_side;

endpackage

### rtl/rgb_hsl_converter.sv
`timescale 1ns / 1ps
// RGB/HSL converter top level: pipeline control, pre-divide math, output register.
// Depends on rhc_pkg and rhc_divider.
//
// Converts between RGB and HSL, one pixel per clock when not stalled; the
// direction register (byte address 0, bit 0) picks RGB to HSL (0) or HSL to
// RGB (1) and may be changed only while the pipeline is empty. A word passes
// four arithmetic stages, then 13 stages of three restoring dividers working
// side by side (one quotient bit each), then the output register. Each stage
// holds its word until the next one frees up, so bubbles close up and input
// is taken while a finished word waits.
module rgb_hsl_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input pixel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [12:0] i_in_first,
    input  logic [11:0] i_in_second,
    input  logic [11:0] i_in_third,
    // Output pixel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [12:0] o_out_first,
    output logic [11:0] o_out_second,
    output logic [11:0] o_out_third
);
    import rhc_pkg::*;

    localparam int N_ST = PRE_STAGES + DIV_QW + 1;
    localparam int LAST = N_ST - 1;

    // Hue ramp weight 0..SIXTY for an angle in sixteenth degrees
    function automatic logic [9:0] ramp_weight(input logic [12:0] hh);
        logic [12:0] fall;
        fall = 13'd3840 - hh;
        if (hh < SIXTY)
            return hh[9:0];
        else if (hh < 13'd2880)
            return SIXTY[9:0];
        else if (hh < 13'd3840)
            return fall[9:0];
        else
            return 10'd0;
    endfunction

    logic              r_direction;
    logic [N_ST-1:0]   r_v;
    logic [N_ST-1:0]   adv;

    // Stage 1: clamped inputs
    logic [12:0] r_x1;
    logic [11:0] r_x2;
    logic [11:0] r_x3;
    // Stage 2: extremes, product l*s, ramp weights
    logic [11:0]        r_delta;
    logic [12:0]        r_sum;
    logic signed [12:0] r_diff;
    t_max_sel           r_sel;
    logic [23:0]        r_ls;
    logic [11:0]        r_s2;
    logic [9:0]         r_t2 [3];
    // Stage 3: division operands, m1 and m2
    logic [25:0] r_nsat;
    logic [25:0] r_nhue;
    logic [12:0] r_dsat;
    logic [12:0] r_dhue;
    logic [23:0] r_m1;
    logic [23:0] r_m2;
    logic [9:0]  r_t3 [3];
    // Stage 4: divider operands
    logic [DIV_NW-1:0] r_num [3];
    logic [DIV_DW-1:0] r_den [3];
    // Side data from stage 2 to the last divider stage
    t_side r_side [1:LAST-1];
    // Output register
    logic [12:0] r_o1;
    logic [11:0] r_o2;
    logic [11:0] r_o3;

    logic [DIV_QW-1:0] quo [3];

    // Configuration port: always ready, one register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, r_direction} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
            r_direction <= pwdata[0];
        end
    end

    // Advance a stage when it is empty or its successor advances
    assign adv[LAST] = !r_v[LAST] || !i_stall;
    genvar k;
    generate
        for (k = 0; k < LAST; k++) begin : g_adv
            assign adv[k] = !r_v[k] || adv[k+1];
        end
    endgenerate

    assign o_stall = !adv[0];
    assign o_valid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < N_ST; j++) begin
                if (adv[j])
                    r_v[j] <= (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // Stage 1: clamp a component or reduce a hue
    logic [12:0] n_x1;
    always_comb begin
        if (r_direction)
            n_x1 = (i_in_first >= TURN) ? i_in_first - TURN : i_in_first;
        else
            n_x1 = (i_in_first > {1'b0, FULL}) ? {1'b0, FULL} : i_in_first;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x1 <= n_x1;
            r_x2 <= i_in_second;
            r_x3 <= i_in_third;
        end
    end

    // Stage 2: max, min and sector; l*s and the three ramp weights
    logic [11:0]        n_mx;
    logic [11:0]        n_mn;
    t_max_sel           n_sel;
    logic [12:0]        n_sum;
    logic [12:0]        n_sum1;
    logic signed [12:0] n_diff;
    logic [12:0]        n_hr;
    logic [12:0]        n_hb;
    t_side              n_side2;
    always_comb begin
        if (r_x1[11:0] >= r_x2 && r_x1[11:0] >= r_x3) begin
            n_sel = SEL_RED;
            n_mx  = r_x1[11:0];
        end else if (r_x2 >= r_x3) begin
            n_sel = SEL_GREEN;
            n_mx  = r_x2;
        end else begin
            n_sel = SEL_BLUE;
            n_mx  = r_x3;
        end
        n_mn = r_x1[11:0];
        if (r_x2 < n_mn) n_mn = r_x2;
        if (r_x3 < n_mn) n_mn = r_x3;
        n_sum  = {1'b0, n_mx} + {1'b0, n_mn};
        n_sum1 = n_sum + 13'd1;
        case (n_sel)
            SEL_RED:   n_diff = $signed({1'b0, r_x2}) - $signed({1'b0, r_x3});
            SEL_GREEN: n_diff = $signed({1'b0, r_x3}) - $signed({1'b0, r_x1[11:0]});
            SEL_BLUE:  n_diff = $signed({1'b0, r_x1[11:0]}) - $signed({1'b0, r_x2});
            default:   n_diff = '0;
        endcase
        // Red looks 120 degrees ahead, blue 120 degrees behind
        n_hr = r_x1 + HUE_OFFSET;
        if (n_hr >= TURN) n_hr = n_hr - TURN;
        n_hb = (r_x1 < HUE_OFFSET) ? r_x1 + (TURN - HUE_OFFSET) : r_x1 - HUE_OFFSET;
        if (r_direction) begin
            n_side2.l       = r_x3;
            n_side2.special = (r_x2 == 12'd0);
        end else begin
            n_side2.l       = n_sum1[12:1];
            n_side2.special = (n_mx == n_mn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_delta   <= n_mx - n_mn;
            r_sum     <= n_sum;
            r_diff    <= n_diff;
            r_sel     <= n_sel;
            r_ls      <= 24'(r_x3) * 24'(r_x2);
            r_s2      <= r_x2;
            r_t2[0]   <= ramp_weight(n_hr);
            r_t2[1]   <= ramp_weight(r_x1);
            r_t2[2]   <= ramp_weight(n_hb);
            r_side[1] <= n_side2;
        end
    end

    // Stage 3: saturation and hue numerators; m1 and m2
    logic [11:0]        n_dn;
    logic [12:0]        n_flip;
    logic [25:0]        n_bd;
    logic signed [27:0] n_hn;
    logic [23:0]        n_l4095;
    logic [23:0]        n_s4095;
    logic [23:0]        n_m2;
    logic [24:0]        n_m1;
    always_comb begin
        n_flip = 13'd8190 - r_sum;
        n_dn   = (r_sum < {1'b0, FULL}) ? r_sum[11:0] : n_flip[11:0];
        case (r_sel)
            SEL_RED:   n_bd = 26'(r_delta) * 26'd11520;
            SEL_GREEN: n_bd = 26'(r_delta) * 26'd3840;
            SEL_BLUE:  n_bd = 26'(r_delta) * 26'd7680;
            default:   n_bd = '0;
        endcase
        n_hn = $signed({2'b00, n_bd})
             + $signed({{15{r_diff[12]}}, r_diff}) * 28'sd1920
             + $signed({16'd0, r_delta});
        n_l4095 = {r_side[2-1].l, 12'd0} - 24'(r_side[2-1].l);
        n_s4095 = {r_s2, 12'd0} - 24'(r_s2);
        if (!r_side[2-1].l[11])
            n_m2 = n_l4095 + r_ls;
        else
            n_m2 = n_l4095 + n_s4095 - r_ls;
        n_m1 = {n_l4095, 1'b0} - {1'b0, n_m2};
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_nsat    <= 26'(r_delta) * 26'd8190 + 26'(n_dn);
            r_nhue    <= n_hn[25:0];
            r_dsat    <= {n_dn, 1'b0};
            r_dhue    <= {r_delta, 1'b0};
            r_m1      <= n_m1[23:0];
            r_m2      <= n_m2;
            r_t3      <= r_t2;
            r_side[2] <= r_side[1];
        end
    end

    // Stage 4: weighted ramp sums, then pick the divider operands
    logic [33:0] n_ramp [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ramp[c] = 34'(r_m1) * 34'(SIXTY[9:0] - r_t3[c])
                      + 34'(r_m2) * 34'(r_t3[c]) + RAMP_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            if (r_direction) begin
                for (int c = 0; c < 3; c++) begin
                    r_num[c] <= {1'b0, n_ramp[c]};
                    r_den[c] <= RAMP_DEN;
                end
            end else begin
                r_num[0] <= DIV_NW'(r_nhue);
                r_den[0] <= DIV_DW'(r_dhue);
                r_num[1] <= DIV_NW'(r_nsat);
                r_den[1] <= DIV_DW'(r_dsat);
                r_num[2] <= '0;
                r_den[2] <= DIV_DW'(1);
            end
            r_side[3] <= r_side[2];
        end
    end

    // Divider stages, side data kept in step
    generate
        for (k = 0; k < 3; k++) begin : g_div
            rhc_divider u_div (
                .i_clk (i_clk),
                .i_adv (adv[PRE_STAGES +: DIV_QW]),
                .i_num (r_num[k]),
                .i_den (r_den[k]),
                .o_quo (quo[k])
            );
        end
        for (k = PRE_STAGES; k < LAST; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (adv[k])
                    r_side[k] <= r_side[k-1];
            end
        end
    endgenerate

    // Output: wrap the hue, override gray or zero-saturation pixels
    logic [12:0] n_o1;
    logic [11:0] n_o2;
    logic [11:0] n_o3;
    t_side       side_out;
    always_comb begin
        side_out = r_side[LAST-1];
        if (!r_direction) begin
            n_o1 = (quo[0] >= TURN) ? quo[0] - TURN : quo[0];
            n_o2 = quo[1][11:0];
            n_o3 = side_out.l;
            if (side_out.special) begin
                n_o1 = '0;
                n_o2 = '0;
            end
        end else if (side_out.special) begin
            n_o1 = {1'b0, side_out.l};
            n_o2 = side_out.l;
            n_o3 = side_out.l;
        end else begin
            n_o1 = quo[0];
            n_o2 = quo[1][11:0];
            n_o3 = quo[2][11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_o1 <= n_o1;
            r_o2 <= n_o2;
            r_o3 <= n_o3;
        end
    end

    assign o_out_first  = r_o1;
    assign o_out_second = r_o2;
    assign o_out_third  = r_o3;

endmodule

### rtl/rhc_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rhc_pkg for its widths; stage enables come from the converter.
module rhc_divider (
    input  logic                        i_clk,
    input  logic [rhc_pkg::DIV_QW-1:0]  i_adv,
    input  logic [rhc_pkg::DIV_NW-1:0]  i_num,
    input  logic [rhc_pkg::DIV_DW-1:0]  i_den,
    output logic [rhc_pkg::DIV_QW-1:0]  o_quo
);
    import rhc_pkg::*;

    logic [DIV_DW-1:0] r_rem [DIV_QW];
    logic [DIV_DW-1:0] r_den [DIV_QW];
    logic [DIV_QW-1:0] r_low [DIV_QW];
    logic [DIV_QW-1:0] r_quo [DIV_QW];

    genvar k;
    generate
        for (k = 0; k < DIV_QW; k++) begin : g_step
            logic [DIV_DW-1:0] rem_in;
            logic [DIV_DW-1:0] den_in;
            logic [DIV_QW-1:0] low_in;
            logic [DIV_QW-1:0] quo_in;
            logic [DIV_DW:0]   trial;
            logic [DIV_DW:0]   diff;
            logic              ge;

            // Pick the stage input: the operands or the previous stage
            if (k == 0) begin : g_first
                assign rem_in = i_num[DIV_NW-1:DIV_QW];
                assign low_in = i_num[DIV_QW-1:0];
                assign quo_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign low_in = r_low[k-1];
                assign quo_in = r_quo[k-1];
                assign den_in = r_den[k-1];
            end

            // Shift in one dividend bit and try the subtract
            assign trial = {rem_in, low_in[DIV_QW-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                    r_low[k] <= {low_in[DIV_QW-2:0], 1'b0};
                    r_quo[k] <= {quo_in[DIV_QW-2:0], ge};
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_QW-1];

endmodule

### rtl/rhc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the RGB/HSL converter, bound to the top level.
// Depends on rhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [12:0] o_out_first,
    input logic [11:0] o_out_second,
    input logic [11:0] o_out_third
);
    import rhc_pkg::*;

    // An empty output register means the whole pipeline can move
    `RHC_ASSERT_IMP(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall)

    // Hue or red never reaches a full turn
    `RHC_ASSERT_IMP(a_first_in_range, i_clk, i_rst_n, o_valid, o_out_first < TURN)

    // Hold a stalled word
    `RHC_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_first) && $stable(o_out_second) && $stable(o_out_third))

    // Reset drops every word in flight
    `RHC_ASSERT_NEXT_ANY(a_reset_empties, i_clk, !i_rst_n, !o_valid)

endmodule

bind rgb_hsl_converter rhc_checker u_rhc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_first  (o_out_first),
    .o_out_second (o_out_second),
    .o_out_third  (o_out_third)
);

### tb/sv/rgb_hsl_converter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the RGB/HSL converter: random and directed pixels, both directions.
// Depends on rhc_pkg and the rgb_hsl_converter RTL.
module rgb_hsl_converter_test;
    import rhc_pkg::*;

    localparam int LATENCY = 18;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint CF = 4095;
    localparam longint C60 = 960;
    localparam longint CTURN = 5760;

    typedef struct packed {
        logic [12:0] first;
        logic [11:0] second;
        logic [11:0] third;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [12:0] i_in_first = '0;
    logic [11:0] i_in_second = '0;
    logic [11:0] i_in_third = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [12:0] o_out_first;
    logic [11:0] o_out_second;
    logic [11:0] o_out_third;

    t_pixel pending_pixels[$];
    logic   to_rgb_mode = 1'b0;
    int     error_count = 0;
    int     idle_cycles = 0;
    int     hold_off = 0;
    bit     bursty_stall = 1'b1;

    rgb_hsl_converter dut (.*);

    always #5 i_clk = ~i_clk;

    // Clamp a component to full scale
    function automatic longint clamp_full(longint v);
        return (v > CF) ? CF : v;
    endfunction

    // Hue ramp with lo and hi scaled by full scale
    function automatic longint hue_ramp(longint lo, longint hi, longint hh);
        longint t;
        longint den;
        den = C60 * CF;
        if (hh > CTURN) hh -= CTURN;
        if (hh < 0) hh += CTURN;
        if (hh < C60) t = hh;
        else if (hh < 3 * C60) t = C60;
        else if (hh < 4 * C60) t = 4 * C60 - hh;
        else t = 0;
        return (2 * (lo * C60 + (hi - lo) * t) + den) / (2 * den);
    endfunction

    // Compute the converted pixel for the current direction
    function automatic t_pixel convert_pixel(t_pixel px);
        t_pixel res;
        longint a, b, c, mx, mn, sum, delta, den, base, diff, n, h, s, m1, m2;
        a = px.first; b = clamp_full(px.second); c = clamp_full(px.third);
        if (!to_rgb_mode) begin
            a = clamp_full(a);
            mx = a; mn = a;
            if (b > mx) mx = b;
            if (c > mx) mx = c;
            if (b < mn) mn = b;
            if (c < mn) mn = c;
            sum = mx + mn;
            h = 0; s = 0;
            if (mx != mn) begin
                delta = mx - mn;
                den = (sum < CF) ? sum : (2 * CF - sum);
                s = (2 * CF * delta + den) / (2 * den);
                if (a == mx) begin
                    base = CTURN; diff = b - c;
                end else if (b == mx) begin
                    base = 2 * C60; diff = c - a;
                end else begin
                    base = 4 * C60; diff = a - b;
                end
                n = base * delta + C60 * diff;
                h = (2 * n + delta) / (2 * delta);
                if (h >= CTURN) h -= CTURN;
            end
            res.first = h[12:0]; res.second = s[11:0];
            res.third = 12'((sum + 1) >> 1);
        end else begin
            a = a % CTURN;
            if (b == 0) begin
                res.first = c[12:0]; res.second = c[11:0]; res.third = c[11:0];
            end else begin
                if (2 * c <= CF) m2 = c * (CF + b);
                else m2 = c * CF + b * CF - c * b;
                m1 = 2 * c * CF - m2;
                res.first = 13'(hue_ramp(m1, m2, a + 2 * C60));
                res.second = 12'(hue_ramp(m1, m2, a));
                res.third = 12'(hue_ramp(m1, m2, a - 2 * C60));
            end
        end
        return res;
    endfunction

    // Offer one pixel and hold it until taken; valid stays up for the next one
    task automatic send_pixel(int f, int s, int t);
        t_pixel px;
        px = {13'(f), 12'(s), 12'(t)};
        i_valid <= 1'b1;
        i_in_first <= px.first; i_in_second <= px.second; i_in_third <= px.third;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(convert_pixel(px));
        @(negedge i_clk);
    endtask

    // Drop valid between bursts
    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    // Random gap between bursts
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            stop_sending();
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Wait for the pipeline to drain
    task automatic drain();
        stop_sending();
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Register write: setup then access
    task automatic write_direction(logic dir);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * REG_DIRECTION); pwdata <= {31'd0, dir};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        to_rgb_mode = dir;
    endtask

    task automatic test_directed_rgb();
        write_direction(1'b0);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 4095);
        send_pixel(4095, 0, 0);
        send_pixel(0, 4095, 0);
        send_pixel(0, 0, 4095);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 4095, 4095);
        send_pixel(4095, 0, 4095);
        send_pixel(4095, 1, 0);
        send_pixel(8191, 4095, 100);
        send_pixel(2000, 2000, 1000);
        send_pixel(1, 0, 0);
        drain();
    endtask

    task automatic test_directed_hsl();
        write_direction(1'b1);
        send_pixel(0, 0, 2000);
        send_pixel(0, 4095, 2047);
        send_pixel(5759, 4095, 2048);
        send_pixel(5760, 4095, 1000);
        send_pixel(8191, 4095, 4095);
        send_pixel(960, 2000, 3000);
        send_pixel(2880, 1, 1);
        send_pixel(3840, 4095, 0);
        send_pixel(1919, 3000, 4095);
        send_pixel(4800, 4095, 4095);
        drain();
    endtask

    // Random pixels, mostly in range, some beyond
    task automatic test_random(logic dir, int count);
        int f;
        write_direction(dir);
        repeat (count) begin
            f = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191))
                : int'($urandom_range(0, dir ? 5759 : 4095));
            send_pixel(f, ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 4095)),
                       int'($urandom_range(0, 4095)));
            sender_gap();
        end
        drain();
    endtask

    // Long receiver hold-off with the sender pushing on
    task automatic test_backpressure();
        write_direction(1'b0);
        hold_off = 120;
        repeat (60) send_pixel(int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                               int'($urandom_range(0, 4095)));
        drain();
    endtask

    // Receiver stall pattern: bursts of stall, stretches without
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0) bursty_stall <= ~bursty_stall;
            i_stall <= bursty_stall ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result %h %h %h", o_out_first, o_out_second, o_out_third);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (o_out_first !== exp_px.first) begin
                    $error("out_first expected %0d got %0d", exp_px.first, o_out_first);
                    error_count++;
                end
                if (o_out_second !== exp_px.second) begin
                    $error("out_second expected %0d got %0d", exp_px.second, o_out_second);
                    error_count++;
                end
                if (o_out_third !== exp_px.third) begin
                    $error("out_third expected %0d got %0d", exp_px.third, o_out_third);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_hsl_converter test failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_rgb();
        test_directed_hsl();
        test_random(1'b0, 500);
        test_random(1'b1, 500);
        test_backpressure();
        test_random(1'b1, 60);
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("rgb_hsl_converter test passed");
        else
            $display("rgb_hsl_converter test failed");
        $finish;
    end
endmodule
